// ----- hdl/mts_pkg.sv -----
// shared types and constants for the min tracking stack
package mts_pkg;

	localparam int VALUE_W = 32;
	localparam int OCC_W   = 9;
	localparam int OUT_W   = 80;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic    push;
		logic    pop_deep;
		logic    pop_last;
		logic    load_top;
		logic    out_load;
		status_t status;
	} cmd_t;

	// stack status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic single;
		logic full;
	} stat_t;

endpackage

// ----- hdl/mts_ctrl.sv -----
// request controller: handshakes, sequencing of refills after pops
module mts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic           s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  mts_pkg::stat_t stat,
	output mts_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOAD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   m_valid_q;
	logic   accept;
	logic   is_push;

	assign s_tready = (state_q == S_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign is_push  = (s_tuser == mts_pkg::REQ_PUSH);
	assign m_tvalid = m_valid_q;

	always_comb begin
		cmd.push     = accept && is_push && !stat.full;
		cmd.pop_deep = accept && !is_push && !stat.empty && !stat.single;
		cmd.pop_last = accept && !is_push && stat.single;
		cmd.load_top = (state_q == S_LOAD);
		cmd.out_load = (accept && !cmd.pop_deep) || (state_q == S_LOAD);
		if (accept && is_push && stat.full) begin
			cmd.status = mts_pkg::ST_OVERFLOW;
		end else if (accept && !is_push && stat.empty) begin
			cmd.status = mts_pkg::ST_UNDERFLOW;
		end else begin
			cmd.status = mts_pkg::ST_OK;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.pop_deep) begin
					state_nxt = S_LOAD;
				end
			end
			S_LOAD: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/mts_dpath.sv -----
// stack datapath: top entry registers, entry memory, count and result register
module mts_dpath #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [mts_pkg::VALUE_W-1:0] push_value,
	input  mts_pkg::cmd_t                  cmd,
	output mts_pkg::stat_t                 stat,
	output logic [mts_pkg::OUT_W-1:0]      result
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = 2 * mts_pkg::VALUE_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [CW-1:0] count_m1;
	logic [AW-1:0] count_m2;

	logic signed [mts_pkg::VALUE_W-1:0] top_val_q;
	logic signed [mts_pkg::VALUE_W-1:0] top_min_q;
	logic signed [mts_pkg::VALUE_W-1:0] new_min;
	logic signed [mts_pkg::VALUE_W-1:0] res_top;
	logic signed [mts_pkg::VALUE_W-1:0] res_min;

	// entries below the top, min in the upper half
	logic [EW-1:0] mem [STACK_DEPTH];
	logic [EW-1:0] rd_data_q;

	logic [mts_pkg::OUT_W-1:0] result_q;

	assign stat.empty  = (count_q == '0);
	assign stat.single = (count_q == CW'(1));
	assign stat.full   = (count_q == CW'(STACK_DEPTH));

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q[AW-1:0] - AW'(2);

	assign new_min = (stat.empty || (push_value < top_min_q)) ? push_value : top_min_q;

	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.pop_deep || cmd.pop_last) begin
			count_nxt = count_m1;
		end
	end

	always_comb begin
		if (count_nxt == '0) begin
			res_top = '0;
			res_min = '0;
		end else if (cmd.push) begin
			res_top = push_value;
			res_min = new_min;
		end else if (cmd.load_top) begin
			res_top = rd_data_q[mts_pkg::VALUE_W-1:0];
			res_min = rd_data_q[EW-1:mts_pkg::VALUE_W];
		end else begin
			res_top = top_val_q;
			res_min = top_min_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !stat.empty) begin
			mem[count_m1[AW-1:0]] <= {top_min_q, top_val_q};
		end
		rd_data_q <= mem[count_m2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_val_q <= push_value;
			top_min_q <= new_min;
		end else if (cmd.load_top) begin
			top_val_q <= rd_data_q[mts_pkg::VALUE_W-1:0];
			top_min_q <= rd_data_q[EW-1:mts_pkg::VALUE_W];
		end
		if (cmd.out_load) begin
			result_q <= {4'b0, cmd.status, mts_pkg::OCC_W'(count_nxt),
				(count_nxt == '0), res_min, res_top};
		end
	end

	assign result = result_q;

endmodule

// ----- hdl/min_tracking_stack.sv -----
// min tracking stack: bounded lifo of signed words with running minimum
//
// requests enter on the s_ channel: s_tuser selects push (0) or pop (1),
// s_tdata carries the value to push. every request yields one result word
// on the m_ channel with the new top, the minimum of all stored entries,
// an empty flag, the occupancy and a status (ok, overflow, underflow).
// top and minimum read zero when the stack is empty.
//
// the top entry lives in registers, the entries below it in a memory.
// a push, or a pop that leaves the stack empty or fails, is taken in the
// cycle it is accepted and its result is registered. a pop that exposes
// a stored entry passes through the load state: the memory read is
// registered before the entry is moved into the top registers.
//
// the result register frees as the receiver takes the word, so a new
// request is accepted while the last result is being taken. when m_tready
// is held low the result waits and no further request is accepted.
// reset empties the stack; the memory itself is not cleared.
module min_tracking_stack #(
	parameter int STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // push_value
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	// top_value, min_value, is_empty, occupancy, status, zero fill
	output logic [79:0] m_tdata
);

	mts_pkg::cmd_t  cmd;
	mts_pkg::stat_t stat;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mts_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_value ($signed(s_tdata)),
		.cmd        (cmd),
		.stat       (stat),
		.result     (m_tdata)
	);

endmodule

// ----- hdl/mts_checker.sv -----
// port level checks for the min tracking stack, bound to the top level
module mts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> (m_tdata[63:0] == 64'd0) && (m_tdata[73:65] == 9'd0))
		else $error("empty result with nonzero top, min or occupancy");

	a_occ_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[73:65] == 9'd0) |-> m_tdata[64])
		else $error("zero occupancy without empty flag");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[75:74] == mts_pkg::ST_UNDERFLOW) |-> m_tdata[64])
		else $error("underflow on a nonempty stack");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[64] |-> $signed(m_tdata[63:32]) <= $signed(m_tdata[31:0]))
		else $error("minimum above top value");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
